@@ hw/rtl/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths and types for the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int LANES       = 2 * NUM_AXES;           // min and max per axis
  localparam int MAG_W       = COORD_WIDTH;            // |corner - origin|, |dir|
  localparam int QUO_W       = COORD_WIDTH + FRAC_BITS; // quotient bits, one per stage
  localparam int T_W         = COORD_WIDTH + FRAC_BITS; // signed slab parameter

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [MAG_W-1:0]       mag_t;
  typedef logic [QUO_W-1:0]       quo_t;
  typedef logic signed [T_W-1:0]  tpar_t;

  // Per-word flags that ride alongside the divider lanes.
  typedef struct packed {
    logic [LANES-1:0]    neg;    // quotient sign per lane
    logic [NUM_AXES-1:0] dzero;  // direction component is zero
    logic                zmiss;  // zero-direction slab misses the origin
  } side_t;

endpackage

@@ hw/rtl/rbst_in_if.sv @@
// ----------------------------------------------------------------------------
// rbst_in_if
// Request channel: one ray and one box per word.
// ----------------------------------------------------------------------------
interface rbst_in_if import rbst_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

@@ hw/rtl/rbst_out_if.sv @@
// ----------------------------------------------------------------------------
// rbst_out_if
// Response channel: one hit flag per word.
// ----------------------------------------------------------------------------
interface rbst_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ hw/rtl/rbst_divider.sv @@
// ----------------------------------------------------------------------------
// rbst_divider
// Six-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rbst_divider import rbst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  quo_t  in_num [LANES],
  input  mag_t  in_den [LANES],
  input  side_t in_side,
  output logic  out_vld,
  output quo_t  out_quo [LANES],
  output side_t out_side
);

  mag_t  rem_q  [QUO_W+1][LANES];
  quo_t  num_q  [QUO_W+1][LANES];  // dividend shifts out, quotient shifts in
  mag_t  den_q  [QUO_W+1][LANES];
  side_t side_q [QUO_W+1];
  logic  vld_q  [QUO_W+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_q[0][l] = '0;
      num_q[0][l] = in_num[l];
      den_q[0][l] = in_den[l];
    end
    side_q[0] = in_side;
    vld_q[0]  = in_vld;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s+1] <= side_q[s];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;

      always_comb begin
        trial = {rem_q[s][l], num_q[s][l][QUO_W-1]};
        diff  = trial - {1'b0, den_q[s][l]};
        ge    = trial >= {1'b0, den_q[s][l]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s+1][l] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          num_q[s+1][l] <= {num_q[s][l][QUO_W-2:0], ge};
          den_q[s+1][l] <= den_q[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = num_q[QUO_W][l];
    end
  end
  assign out_side = side_q[QUO_W];
  assign out_vld  = vld_q[QUO_W];

endmodule

@@ hw/rtl/rbst_combine.sv @@
// ----------------------------------------------------------------------------
// rbst_combine
// Signs and saturates the quotients, orders each slab, then narrows the
// interval over the axes and registers the hit flag.
// ----------------------------------------------------------------------------
module rbst_combine import rbst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  quo_t  in_quo [LANES],
  input  side_t in_side,
  output logic  out_vld,
  output logic  hit
);

  tpar_t t_val   [LANES];
  tpar_t slab_lo [NUM_AXES];
  tpar_t slab_hi [NUM_AXES];
  logic [NUM_AXES-1:0] dzero;
  logic  zmiss;
  logic  vld;
  logic  hit_next;

  // Magnitude at or above 2^(T_W-1) saturates; on the negative side that
  // value is itself the limit, so the MSB alone picks the clamp.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!in_side.neg[l]) begin
        t_val[l] = in_quo[l][QUO_W-1] ? {1'b0, {(T_W-1){1'b1}}} : tpar_t'(in_quo[l]);
      end else begin
        t_val[l] = in_quo[l][QUO_W-1] ? {1'b1, {(T_W-1){1'b0}}} : -tpar_t'(in_quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (t_val[2*a] > t_val[2*a+1]) begin
          slab_lo[a] <= t_val[2*a+1];
          slab_hi[a] <= t_val[2*a];
        end else begin
          slab_lo[a] <= t_val[2*a];
          slab_hi[a] <= t_val[2*a+1];
        end
      end
      dzero <= in_side.dzero;
      zmiss <= in_side.zmiss;
    end
  end

  // Running interval; zero-direction slabs are skipped, z only checks overlap.
  always_comb begin
    tpar_t lo;
    tpar_t hi;
    logic  have;
    logic  miss;
    lo   = '0;
    hi   = '0;
    have = 1'b0;
    miss = zmiss;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!dzero[a]) begin
        if (!have) begin
          lo   = slab_lo[a];
          hi   = slab_hi[a];
          have = 1'b1;
        end else if (!miss) begin
          if (lo > slab_hi[a] || slab_lo[a] > hi) begin
            miss = 1'b1;
          end else if (a < NUM_AXES - 1) begin
            if (slab_lo[a] > lo) lo = slab_lo[a];
            if (slab_hi[a] < hi) hi = slab_hi[a];
          end
        end
      end
    end
    hit_next = !miss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule

@@ hw/rtl/ray_box_slab_test_top.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray versus axis-aligned box slab test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ray (origin, direction) and one box (min, max corners),
//   all signed Q16.16; rsp returns one hit flag per request word, in order.
//   Both channels use valid/ready; a word moves when both are high.
//   Throughput: one word per cycle while the pipeline is not held. The
//   stages are one front-end stage forming differences and signs, one
//   divider stage per quotient bit, one stage to saturate and order each
//   slab, and the output register holding the hit flag.
//   All stages advance together; when rsp is stalled with a word waiting in
//   the output register the whole pipeline holds and req.ready drops, so
//   nothing is lost or repeated. A bubble in the output register keeps
//   req.ready high even while rsp.ready is low.
//   Reset (rst, synchronous) clears every valid bit; the pipeline is empty
//   and ready on the next cycle.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top import rbst_pkg::*; (
  input  logic clk,
  input  logic rst,
  rbst_in_if.sink    req,
  rbst_out_if.source rsp
);

  logic  en;
  logic  fe_vld;
  quo_t  fe_num [LANES];
  mag_t  fe_den [LANES];
  side_t fe_side;
  logic  dv_vld;
  quo_t  dv_quo [LANES];
  side_t dv_side;

  coord_t org [NUM_AXES];
  coord_t dir [NUM_AXES];
  coord_t bmn [NUM_AXES];
  coord_t bmx [NUM_AXES];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign org = '{req.origin_x, req.origin_y, req.origin_z};
  assign dir = '{req.dir_x, req.dir_y, req.dir_z};
  assign bmn = '{req.box_min_x, req.box_min_y, req.box_min_z};
  assign bmx = '{req.box_max_x, req.box_max_y, req.box_max_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_vld <= 1'b0;
    end else if (en) begin
      fe_vld <= req.valid;
    end
  end

  // Front end: corner - origin and |dir|, both as magnitude plus sign.
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [COORD_WIDTH:0] dmin;
      logic signed [COORD_WIDTH:0] dmax;
      logic signed [COORD_WIDTH:0] dd;
      logic signed [COORD_WIDTH:0] o;
      logic zm;
      zm = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        o    = {org[a][COORD_WIDTH-1], org[a]};
        dmin = {bmn[a][COORD_WIDTH-1], bmn[a]} - o;
        dmax = {bmx[a][COORD_WIDTH-1], bmx[a]} - o;
        dd   = {dir[a][COORD_WIDTH-1], dir[a]};
        if (dd[COORD_WIDTH]) dd = -dd;
        fe_den[2*a]   <= dd[MAG_W-1:0];
        fe_den[2*a+1] <= dd[MAG_W-1:0];
        fe_num[2*a]   <= {(dmin[COORD_WIDTH] ? mag_t'(-dmin) : dmin[MAG_W-1:0]),
                          {FRAC_BITS{1'b0}}};
        fe_num[2*a+1] <= {(dmax[COORD_WIDTH] ? mag_t'(-dmax) : dmax[MAG_W-1:0]),
                          {FRAC_BITS{1'b0}}};
        fe_side.neg[2*a]   <= dmin[COORD_WIDTH] ^ dir[a][COORD_WIDTH-1];
        fe_side.neg[2*a+1] <= dmax[COORD_WIDTH] ^ dir[a][COORD_WIDTH-1];
        fe_side.dzero[a]   <= (dir[a] == '0);
        // origin outside [min,max] on a flat axis: dmin > 0 or dmax < 0
        if (dir[a] == '0 && ((!dmin[COORD_WIDTH] && dmin != '0) || dmax[COORD_WIDTH])) begin
          zm = 1'b1;
        end
      end
      fe_side.zmiss <= zm;
    end
  end

  rbst_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fe_vld),
    .in_num   (fe_num),
    .in_den   (fe_den),
    .in_side  (fe_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  rbst_combine u_comb (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (dv_vld),
    .in_quo  (dv_quo),
    .in_side (dv_side),
    .out_vld (rsp.valid),
    .hit     (rsp.hit)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Slab test bench: drives rays and boxes through the request channel, predicts
// the hit flag per word and compares it in order against the response channel.
// ----------------------------------------------------------------------------
module tb_top import rbst_pkg::*; ();

  localparam int LATENCY   = QUO_W + 3;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 880;

  typedef struct {
    coord_t org[3];
    coord_t dir[3];
    coord_t bmin[3];
    coord_t bmax[3];
  } ray_box_t;

  logic clk;
  logic rst;

  rbst_in_if  req ();
  rbst_out_if rsp ();

  ray_box_slab_test_top u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  bit   hit_q[$];
  int   mismatches;
  int   wdog;
  int   rsp_stall;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Parameter as signed value; saturated, trunc toward zero.
  function automatic longint slab_param(longint num, longint den);
    longint n, d, ip, r, fr, v;
    bit neg;
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    ip  = n / d;
    r   = n % d;
    fr  = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r  = r << 1;
      fr = fr << 1;
      if (r >= d) begin
        r  = r - d;
        fr = fr | 1;
      end
    end
    v = (ip << FRAC_BITS) | fr;
    if (!neg) begin
      if (ip >= (longint'(1) << (COORD_WIDTH - 1)))
        v = (longint'(1) << (COORD_WIDTH - 1 + FRAC_BITS)) - 1;
      return v;
    end
    if (v > (longint'(1) << (COORD_WIDTH - 1 + FRAC_BITS)))
      v = longint'(1) << (COORD_WIDTH - 1 + FRAC_BITS);
    return -v;
  endfunction

  function automatic bit predict_hit(ray_box_t w);
    longint o, d, mn, mx, a, b, s, lo, hi;
    bit have;
    have = 0;
    lo = 0;
    hi = 0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      o  = longint'($signed(w.org[ax]));
      d  = longint'($signed(w.dir[ax]));
      mn = longint'($signed(w.bmin[ax]));
      mx = longint'($signed(w.bmax[ax]));
      if (d == 0) begin
        if (o < mn || o > mx) return 1'b0;
        continue;
      end
      a = slab_param(mn - o, d);
      b = slab_param(mx - o, d);
      if (a > b) begin
        s = a; a = b; b = s;
      end
      if (!have) begin
        lo = a; hi = b; have = 1;
        continue;
      end
      if (lo > b || a > hi) return 1'b0;
      // z slab only checks overlap
      if (ax < 2) begin
        if (a > lo) lo = a;
        if (b < hi) hi = b;
      end
    end
    return 1'b1;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // valid stays high between back-to-back words; dropped only for a gap
  task automatic send_word(ray_box_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.origin_x  <= w.org[0];  req.origin_y  <= w.org[1];  req.origin_z  <= w.org[2];
    req.dir_x     <= w.dir[0];  req.dir_y     <= w.dir[1];  req.dir_z     <= w.dir[2];
    req.box_min_x <= w.bmin[0]; req.box_min_y <= w.bmin[1]; req.box_min_z <= w.bmin[2];
    req.box_max_x <= w.bmax[0]; req.box_max_y <= w.bmax[1]; req.box_max_z <= w.bmax[2];
    do @(posedge clk); while (!req.ready);
    hit_q.push_back(predict_hit(w));
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return coord_t'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic ray_box_t rand_word();
    ray_box_t w;
    coord_t t;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      w.org[ax]  = rand_coord();
      w.dir[ax]  = ($urandom_range(0, 7) == 0) ? '0 : rand_coord();
      w.bmin[ax] = rand_coord();
      w.bmax[ax] = rand_coord();
      // mostly well-ordered boxes around the origin so hits occur
      if ($urandom_range(0, 3) != 0) begin
        if ($signed(w.bmin[ax]) > $signed(w.bmax[ax])) begin
          t = w.bmin[ax]; w.bmin[ax] = w.bmax[ax]; w.bmax[ax] = t;
        end
        if ($urandom_range(0, 1)) w.org[ax] = w.bmin[ax] + (w.bmax[ax] - w.bmin[ax]) / 2;
      end
    end
    return w;
  endfunction

  function automatic ray_box_t fill_word(coord_t o, coord_t d, coord_t mn, coord_t mx);
    ray_box_t w;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      w.org[ax] = o; w.dir[ax] = d; w.bmin[ax] = mn; w.bmax[ax] = mx;
    end
    return w;
  endfunction

  task automatic test_extremes();
    send_word(fill_word(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff));
    send_word(fill_word(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_word(fill_word(32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_word(fill_word(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff));
    send_word(fill_word(32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
  endtask

  task automatic test_zero_dir();
    ray_box_t w;
    send_word(fill_word(32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000));  // all unbounded
    send_word(fill_word(32'h0, 32'h0, 32'h0, 32'h0));                  // on both faces
    send_word(fill_word(32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000));  // outside
    send_word(fill_word(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0));  // inverted box
    w = fill_word(32'h0, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    w.dir[1] = '0;
    send_word(w);
    w.org[2] = 32'h0005_0000; w.dir[2] = '0;
    send_word(w);
  endtask

  task automatic test_slab_cases();
    ray_box_t w;
    send_word(fill_word(32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000)); // inverted
    // touching intervals: x gives [1,2], y gives [2,3]
    w = fill_word(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    w.bmin[1] = 32'h0002_0000; w.bmax[1] = 32'h0003_0000;
    send_word(w);
    w.bmin[1] = 32'h0002_0001;
    send_word(w);
    // z disjoint from x/y
    w = fill_word(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    w.bmin[2] = 32'h0005_0000; w.bmax[2] = 32'h0006_0000;
    send_word(w);
    // box behind origin still hits
    send_word(fill_word(32'h0, 32'h0001_0000, 32'hfffd_0000, 32'hfffe_0000));
    // fractional quotient
    send_word(fill_word(32'h0, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000));
    send_word(fill_word(32'h0, 32'hfffd_0000, 32'h0001_0000, 32'h0002_0000));
  endtask

  task automatic test_random();
    for (int i = 0; i < N_RANDOM; i++) send_word(rand_word());
  endtask

  // response stall, checks
  always @(posedge clk) begin
    bit exp_hit;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (hit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: hit=%0b", rsp.hit);
        end else begin
          exp_hit = hit_q.pop_front();
          if (rsp.hit !== exp_hit) begin
            mismatches++;
            if (mismatches <= 10) $display("hit mismatch: exp=%0b got=%0b", exp_hit, rsp.hit);
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall <= gap_len();
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    wdog = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.origin_x = '0;  req.origin_y = '0;  req.origin_z = '0;
    req.dir_x = '0;     req.dir_y = '0;     req.dir_z = '0;
    req.box_min_x = '0; req.box_min_y = '0; req.box_min_z = '0;
    req.box_max_x = '0; req.box_max_y = '0; req.box_max_z = '0;
    rsp.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_dir();
    test_slab_cases();
    test_random();
    req.valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
